// File: rtl/core/bpr_pkg.sv
// Shared types and constants of the BMP pixel row decoder.
`default_nettype none

package bpr_pkg;

	// Largest image dimensions; register values above these saturate.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// Depth mode codes.
	localparam logic [2:0] DEPTH_1  = 3'd0;
	localparam logic [2:0] DEPTH_4  = 3'd1;
	localparam logic [2:0] DEPTH_8  = 3'd2;
	localparam logic [2:0] DEPTH_16 = 3'd3;
	localparam logic [2:0] DEPTH_24 = 3'd4;
	localparam logic [2:0] DEPTH_32 = 3'd5;

	// Lane masks and rounding terms of the alpha blend.
	localparam logic [23:0] RB_MASK  = 24'hff00ff;
	localparam logic [23:0] G_MASK   = 24'h00ff00;
	localparam logic [31:0] RB_ROUND = 32'h00800080;
	localparam logic [23:0] G_ROUND  = 24'h008000;

	typedef enum logic [1:0] {
		CMD_PIXEL_BYTE    = 2'd0,
		CMD_PALETTE_WRITE = 2'd1
	} cmd_code_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [23:0] palette_rgb;
		logic [23:0] bg_pixel;
	} item_t;

	typedef struct packed {
		logic [23:0]      pixel_rgb;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last_in_item;
		logic             image_done;
	} pixel_t;

	typedef enum logic [1:0] {
		JOB_PAL_WRITE,
		JOB_PALETTE,
		JOB_DIRECT,
		JOB_BLEND
	} job_kind_t;

	// One accepted item as held by the expansion stage.
	typedef struct packed {
		job_kind_t        kind;
		logic [2:0]       mode;
		logic [7:0]       data;
		logic [23:0]      rgb;
		logic [2:0]       n_m1;
		logic [DIM_W-1:0] col0;
		logic [POS_W-1:0] row_out;
		logic             last_row;
		logic [31:0]      prod_rb;
		logic [23:0]      prod_g;
		logic [23:0]      bg;
	} job_t;

	// One pixel between the expansion stage and the output register.
	typedef struct packed {
		logic             use_pal;
		logic             pal_ok;
		logic [23:0]      rgb;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last_in_item;
		logic             image_done;
	} stage_t;

endpackage

`default_nettype wire

// File: rtl/core/bpr_palette_ram.sv
// Palette memory: one write port and one registered read port.
`default_nettype none

module bpr_palette_ram #(
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [23:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bmp_pixel_row_decoder_top.sv
// Top level of the BMP pixel row decoder.
`default_nettype none

// Takes the bytes of a bottom-up BMP pixel array, or palette writes, and
// gives one 24-bit RGB pixel per transfer with its column and flipped row.
// Each pixel-array byte is decoded and the row counters updated in the cycle
// it is taken; the byte then sits in an expansion stage that issues one pixel
// per cycle while the output is not stalled, so a byte stays in that stage
// until it has given all its pixels: up to eight at 1 bpp, up to two at 4 bpp
// and one otherwise. A palette write passes through it without giving a pixel,
// and a byte that yields no pixel (row padding, or an incomplete 16/24/32 bpp
// pixel) does not enter it at all. In 8, 16, 24 and 32 bpp modes a new byte is
// therefore taken every cycle unless the output stalls. A pixel passes the
// expansion, palette read and output registers. Palette entries must be
// written before use; the palette has no reset and needs no clearing pass.
module bmp_pixel_row_decoder_top #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire bpr_pkg::item_t                     item,
	output logic                                    pixel_valid,
	input  wire logic                               pixel_stall,
	output bpr_pkg::pixel_t                         pixel,
	input  wire logic                               cfg_write,
	input  wire logic [bpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int DW = bpr_pkg::DIM_W;

	// Configuration registers.
	logic [2:0]    depth_mode_q;
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;

	// Row walking state.
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;
	logic [1:0]    rbc_q;
	logic [1:0]    phase_q;
	logic [23:0]   partial_q;

	// Expansion stage.
	logic          job_v_q;
	bpr_pkg::job_t job_q;
	bpr_pkg::job_t job_d;
	logic [2:0]    k_q;

	// Pixel stage and output register.
	logic            v_s2;
	bpr_pkg::stage_t pix_s2;
	bpr_pkg::stage_t pix_d;
	logic            out_v_q;
	bpr_pkg::pixel_t out_q;

	logic [DW-1:0] w;
	logic [DW-1:0] h;
	logic [2:0]    mode;
	logic          active;
	logic [DW-1:0] rem;
	logic [2:0]    need;
	logic          complete;
	logic          multi;
	logic [3:0]    n;
	logic          acc;
	logic          pix_acc;
	logic          load;
	logic          adv;
	logic          emit;
	logic          job_done;

	logic [15:0]   v16;
	logic [23:0]   direct_rgb;
	logic [7:0]    alpha;
	logic [23:0]   src;
	logic [31:0]   diff_rb;
	logic [23:0]   diff_g;

	logic [DW-1:0] col_n;
	logic [DW-1:0] row_n;
	logic [1:0]    rbc_n;
	logic [1:0]    phase_n;
	logic [23:0]   partial_n;

	logic [DW-1:0] col_k;
	logic [7:0]    pal_idx;
	logic [31:0]   rb_sum;
	logic [23:0]   rb_res;
	logic [23:0]   g_sum;
	logic [23:0]   g_res;
	logic [23:0]   pal_rdata;
	logic          pal_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q <= bpr_pkg::DEPTH_8;
			width_q      <= DW'(1);
			height_q     <= DW'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				bpr_pkg::REG_DEPTH_MODE:   depth_mode_q <= cfg_data[2:0];
				bpr_pkg::REG_IMAGE_WIDTH:  width_q      <= cfg_data;
				bpr_pkg::REG_IMAGE_HEIGHT: height_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective dimensions and depth.
	always_comb begin
		w = width_q;
		if (width_q == '0) begin
			w = DW'(1);
		end else if (32'(width_q) > bpr_pkg::MAX_WIDTH) begin
			w = DW'(bpr_pkg::MAX_WIDTH);
		end
		h = height_q;
		if (height_q == '0) begin
			h = DW'(1);
		end else if (32'(height_q) > bpr_pkg::MAX_HEIGHT) begin
			h = DW'(bpr_pkg::MAX_HEIGHT);
		end
		mode = (depth_mode_q > bpr_pkg::DEPTH_32) ? bpr_pkg::DEPTH_8 : depth_mode_q;
	end

	assign active   = col_q < w;
	assign rem      = w - col_q;
	assign need     = mode - 3'd1;
	assign complete = ({1'b0, phase_q} + 3'd1) >= need;
	assign multi    = mode >= bpr_pkg::DEPTH_16;

	// Number of pixels this byte completes.
	always_comb begin
		n = 4'd0;
		if (active) begin
			case (mode)
				bpr_pkg::DEPTH_1: n = (rem >= DW'(8)) ? 4'd8 : rem[3:0];
				bpr_pkg::DEPTH_4: n = (rem >= DW'(2)) ? 4'd2 : 4'd1;
				bpr_pkg::DEPTH_8: n = 4'd1;
				default:          n = complete ? 4'd1 : 4'd0;
			endcase
		end
	end

	assign adv      = !out_v_q || !pixel_stall;
	assign emit     = job_v_q && (job_q.kind != bpr_pkg::JOB_PAL_WRITE) && adv;
	assign job_done = job_v_q && ((job_q.kind == bpr_pkg::JOB_PAL_WRITE) ||
		(adv && (k_q == job_q.n_m1)));
	assign item_stall = job_v_q && !job_done;
	assign acc     = item_valid && !item_stall;
	assign pix_acc = acc && !item.cmd;
	assign load    = acc && (item.cmd || (n != 4'd0));

	// Direct colours and the first half of the blend.
	assign v16 = {item.data_byte, partial_q[7:0]};
	assign direct_rgb = (mode == bpr_pkg::DEPTH_16) ?
		{v16[14:10], 3'b000, v16[9:5], 3'b000, v16[4:0], 3'b000} :
		{item.data_byte, partial_q[15:0]};
	assign alpha   = partial_q[7:0];
	assign src     = {item.data_byte, partial_q[23:8]};
	assign diff_rb = {8'd0, src & bpr_pkg::RB_MASK} - {8'd0, item.bg_pixel & bpr_pkg::RB_MASK};
	assign diff_g  = (src & bpr_pkg::G_MASK) - (item.bg_pixel & bpr_pkg::G_MASK);

	always_comb begin
		job_d          = '0;
		job_d.mode     = mode;
		job_d.n_m1     = 3'(n - 4'd1);
		job_d.col0     = col_q;
		job_d.row_out  = bpr_pkg::POS_W'(h - DW'(1) - row_q);
		job_d.last_row = ({1'b0, row_q} + 14'd1) == {1'b0, h};
		job_d.prod_rb  = diff_rb * {24'd0, alpha};
		job_d.prod_g   = diff_g * {16'd0, alpha};
		job_d.bg       = item.bg_pixel;
		if (item.cmd) begin
			job_d.kind = bpr_pkg::JOB_PAL_WRITE;
			job_d.data = item.palette_index;
			job_d.rgb  = item.palette_rgb;
		end else begin
			job_d.data = item.data_byte;
			job_d.rgb  = direct_rgb;
			if (!multi) begin
				job_d.kind = bpr_pkg::JOB_PALETTE;
			end else if (mode == bpr_pkg::DEPTH_32) begin
				job_d.kind = bpr_pkg::JOB_BLEND;
			end else begin
				job_d.kind = bpr_pkg::JOB_DIRECT;
			end
		end
	end

	// Counter update for a pixel-array byte.
	always_comb begin
		col_n     = col_q + DW'(n);
		rbc_n     = rbc_q + 2'd1;
		phase_n   = phase_q;
		partial_n = partial_q;
		row_n     = row_q;
		if (active) begin
			if (!multi || complete) begin
				phase_n   = 2'd0;
				partial_n = '0;
			end else begin
				partial_n = partial_q | (24'(item.data_byte) << {phase_q, 3'b000});
				phase_n   = phase_q + 2'd1;
			end
		end
		// The row ends once the pixels are out and the padding reaches a word boundary.
		if ((col_n >= w) && (rbc_n == 2'd0)) begin
			col_n     = '0;
			phase_n   = 2'd0;
			partial_n = '0;
			row_n     = (({1'b0, row_q} + 14'd1) >= {1'b0, h}) ? '0 : row_q + DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			rbc_q     <= 2'd0;
			phase_q   <= 2'd0;
			partial_q <= '0;
		end else if (pix_acc) begin
			col_q     <= col_n;
			row_q     <= row_n;
			rbc_q     <= rbc_n;
			phase_q   <= phase_n;
			partial_q <= partial_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			k_q     <= 3'd0;
		end else if (load) begin
			job_v_q <= 1'b1;
			k_q     <= 3'd0;
		end else if (job_done) begin
			job_v_q <= 1'b0;
		end else if (emit) begin
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job_d;
		end
	end

	// Expansion: pixel k of the held byte.
	always_comb begin
		col_k = job_q.col0 + DW'(k_q);
		case (job_q.mode)
			bpr_pkg::DEPTH_1: pal_idx = {7'd0, job_q.data[3'd7 - k_q]};
			bpr_pkg::DEPTH_4: pal_idx = (k_q == 3'd0) ? {4'd0, job_q.data[7:4]} :
				{4'd0, job_q.data[3:0]};
			default:          pal_idx = job_q.data;
		endcase
		rb_sum = job_q.prod_rb + bpr_pkg::RB_ROUND;
		rb_res = (rb_sum[31:8] + (job_q.bg & bpr_pkg::RB_MASK)) & bpr_pkg::RB_MASK;
		g_sum  = job_q.prod_g + bpr_pkg::G_ROUND;
		g_res  = ({8'd0, g_sum[23:8]} + (job_q.bg & bpr_pkg::G_MASK)) & bpr_pkg::G_MASK;

		pix_d.use_pal      = job_q.kind == bpr_pkg::JOB_PALETTE;
		pix_d.pal_ok       = 32'(pal_idx) < PALETTE_ENTRIES;
		pix_d.rgb          = (job_q.kind == bpr_pkg::JOB_BLEND) ? (rb_res | g_res) : job_q.rgb;
		pix_d.column       = col_k[bpr_pkg::POS_W-1:0];
		pix_d.row          = job_q.row_out;
		pix_d.last_in_item = k_q == job_q.n_m1;
		pix_d.image_done   = job_q.last_row && (col_k == (w - DW'(1)));
	end

	assign pal_we = job_v_q && (job_q.kind == bpr_pkg::JOB_PAL_WRITE) &&
		(32'(job_q.data) < PALETTE_ENTRIES);

	bpr_palette_ram #(
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(job_q.data[PAL_AW-1:0]),
		.wdata(job_q.rgb),
		.re   (adv),
		.raddr(pal_idx[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s2    <= emit;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= pix_d;
			out_q.pixel_rgb    <= pix_s2.use_pal ? (pix_s2.pal_ok ? pal_rdata : 24'd0) :
				pix_s2.rgb;
			out_q.column       <= pix_s2.column;
			out_q.row          <= pix_s2.row;
			out_q.last_in_item <= pix_s2.last_in_item;
			out_q.image_done   <= pix_s2.image_done;
		end
	end

	assign pixel_valid = out_v_q;
	assign pixel       = out_q;

endmodule

`default_nettype wire

// File: rtl/core/bpr_checker.sv
// Port checker of the BMP pixel row decoder, bound to the top level.
`default_nettype none

module bpr_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            pixel_valid,
	input wire logic            pixel_stall,
	input wire bpr_pkg::pixel_t pixel
);

	// The final pixel of an image is always the last one its byte yields.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel.image_done |-> pixel.last_in_item)
		else $error("image_done without last_in_item");

	// The final pixel lies on the top output row.
	a_done_on_top_row: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel.image_done |-> pixel.row == '0)
		else $error("image_done away from row zero");

	// Pixels of one byte follow each other without gaps.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && !pixel.last_in_item |=> pixel_valid)
		else $error("gap inside the pixels of one byte");

	a_burst_column: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && !pixel.last_in_item |=>
			pixel.column == $past(pixel.column) + 12'd1)
		else $error("column does not step inside a byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
		else $error("stalled pixel transfer changed");

endmodule

bind bmp_pixel_row_decoder_top bpr_checker u_bpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pixel_valid(pixel_valid),
	.pixel_stall(pixel_stall),
	.pixel      (pixel)
);

`default_nettype wire
